FILE: src/cau_pkg.sv
// Shared types, constants and helpers for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_EXPONENT = 15;
  localparam int PROD_BITS    = 2 * WORD_BITS;
  localparam int ACC_BITS     = PROD_BITS + 2;
  localparam int DIV_STEPS    = PROD_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_POW = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DIV0 = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic [2:0] K_RE_RE  = 3'd0;
  localparam logic [2:0] K_IM_IM  = 3'd1;
  localparam logic [2:0] K_RE_IM  = 3'd2;
  localparam logic [2:0] K_IM_RE  = 3'd3;
  localparam logic [2:0] K_DEN_RE = 3'd4;
  localparam logic [2:0] K_DEN_IM = 3'd5;

  localparam logic signed [ACC_BITS-1:0] WMAX =
    {{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] WMIN =
    {{(ACC_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_ACC,
    ST_FIX,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  typedef struct packed {
    logic                 sat;
    logic [WORD_BITS-1:0] val;
  } sat_word_t;

  function automatic sat_word_t sat_word(input logic signed [ACC_BITS-1:0] v);
    sat_word_t r;
    if (v > WMAX) begin
      r.sat = 1'b1;
      r.val = WMAX[WORD_BITS-1:0];
    end else if (v < WMIN) begin
      r.sat = 1'b1;
      r.val = WMIN[WORD_BITS-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/cau_mult.sv
// Shared signed multiplier with registered product.
`default_nettype none
module cau_mult
  import cau_pkg::*;
(
  input  wire                          clk,
  input  wire  signed [WORD_BITS-1:0]  a,
  input  wire  signed [WORD_BITS-1:0]  b,
  output logic signed [PROD_BITS-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

FILE: src/cau_div.sv
// Restoring bit-serial divider for the fractional quotient.
`default_nettype none
module cau_div
  import cau_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire  [PROD_BITS-1:0]   num,
  input  wire  [PROD_BITS-1:0]   den,
  output div_stat_t              stat,
  output logic [WORD_BITS-1:0]   q
);

  logic [PROD_BITS-1:0]    rem;
  logic [PROD_BITS-1:0]    dv;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    ovf;
  logic                    done;
  logic [PROD_BITS:0]      r2;
  logic [PROD_BITS:0]      diff;
  logic                    ge;

  assign r2   = {rem, dv[PROD_BITS-1]};
  assign diff = r2 - {1'b0, den};
  assign ge   = (r2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dv  <= num;
      q   <= '0;
      ovf <= 1'b0;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[PROD_BITS-1:0] : r2[PROD_BITS-1:0];
      dv  <= {dv[PROD_BITS-2:0], 1'b0};
      q   <= {q[WORD_BITS-2:0], ge};
      ovf <= ovf | q[WORD_BITS-1];
      cnt <= cnt + 1'b1;
    end
  end

  assign stat.done = done;
  assign stat.ovf  = ovf;

endmodule
`default_nettype wire

FILE: src/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: sequencer, accumulators and result register.
//
//   channel | signals                                        | dir
//   input   | in_valid in_ready func a_re a_im b_re b_im exponent | in
//   output  | out_valid out_ready res_re res_im status        | out
//
// Add and subtract go through ST_ADD; multiply runs four products, power
// one multiply per exponent step, divide six products and two divider runs.
// Reset clears the sequencer and the output valid.
// A new transaction is taken only when the sequencer is idle; a finished
// result waits in the output register while the next one is taken.
`default_nettype none
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [2:0]                   func,
  input  wire  signed [WORD_BITS-1:0]  a_re,
  input  wire  signed [WORD_BITS-1:0]  a_im,
  input  wire  signed [WORD_BITS-1:0]  b_re,
  input  wire  signed [WORD_BITS-1:0]  b_im,
  input  wire  [3:0]                   exponent,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [WORD_BITS-1:0]  res_re,
  output logic signed [WORD_BITS-1:0]  res_im,
  output logic [1:0]                   status
);

  state_t state, state_next;

  logic [2:0]                  func_r;
  logic [3:0]                  exp_r;
  logic signed [WORD_BITS-1:0] xr, xi, yr, yi;
  logic [2:0]                  k;
  logic signed [ACC_BITS-1:0]  acc_re, acc_im;
  logic [PROD_BITS-1:0]        den;
  logic                        sat_r;
  logic                        div0;
  logic                        div_part;
  logic                        div_start;

  logic signed [WORD_BITS-1:0] ma, mb;
  logic signed [PROD_BITS-1:0] p;
  logic signed [ACC_BITS-1:0]  pe;
  logic                        is_div;
  logic [2:0]                  k_last;
  logic [3:0]                  n_in;
  logic                        accept;

  logic signed [ACC_BITS-1:0]  acc_sel;
  logic [PROD_BITS-1:0]        num_mag;
  div_stat_t                   dstat;
  logic [WORD_BITS-1:0]        dq;
  logic signed [ACC_BITS-1:0]  qv;
  sat_word_t                   qs;
  sat_word_t                   fre, fim;
  sat_word_t                   sre, sim;
  logic signed [ACC_BITS-1:0]  add_re, add_im;

  assign accept = in_valid && in_ready;
  assign is_div = (func_r == FUNC_DIV);
  assign k_last = is_div ? K_DEN_IM : K_IM_RE;
  assign n_in   = (exponent > 4'(MAX_EXPONENT)) ? 4'(MAX_EXPONENT) : exponent;
  assign pe     = {{(ACC_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};

  always_comb begin
    case (k)
      K_RE_RE:  begin ma = xr; mb = yr; end
      K_IM_IM:  begin ma = xi; mb = yi; end
      K_RE_IM:  begin ma = xr; mb = yi; end
      K_IM_RE:  begin ma = xi; mb = yr; end
      K_DEN_RE: begin ma = yr; mb = yr; end
      K_DEN_IM: begin ma = yi; mb = yi; end
      default:  begin ma = xr; mb = yr; end
    endcase
  end

  cau_mult u_mult (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (p)
  );

  assign acc_sel = div_part ? acc_im : acc_re;
  always_comb begin
    logic signed [ACC_BITS-1:0] m;
    m       = acc_sel[ACC_BITS-1] ? -acc_sel : acc_sel;
    num_mag = m[PROD_BITS-1:0];
  end

  cau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_mag),
    .den   (den),
    .stat  (dstat),
    .q     (dq)
  );

  always_comb begin
    qv = {{(ACC_BITS-WORD_BITS){1'b0}}, dq};
    if (acc_sel[ACC_BITS-1]) begin
      qv = -qv;
    end
    qs = sat_word(qv);
    if (dstat.ovf) begin
      qs.sat = 1'b1;
      qs.val = acc_sel[ACC_BITS-1] ? WMIN[WORD_BITS-1:0] : WMAX[WORD_BITS-1:0];
    end
  end

  assign fre = sat_word(acc_re >>> FRAC_BITS);
  assign fim = sat_word(acc_im >>> FRAC_BITS);

  always_comb begin
    if (func_r == FUNC_SUB) begin
      add_re = ACC_BITS'(xr) - ACC_BITS'(yr);
      add_im = ACC_BITS'(xi) - ACC_BITS'(yi);
    end else begin
      add_re = ACC_BITS'(xr) + ACC_BITS'(yr);
      add_im = ACC_BITS'(xi) + ACC_BITS'(yi);
    end
  end
  assign sre = sat_word(add_re);
  assign sim = sat_word(add_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (func)
            FUNC_ADD, FUNC_SUB: state_next = ST_ADD;
            FUNC_MUL, FUNC_DIV: state_next = ST_MUL;
            FUNC_POW:           state_next = (n_in == 4'd0) ? ST_DONE : ST_MUL;
            default:            state_next = ST_DONE;
          endcase
        end
      end
      ST_ADD: state_next = ST_DONE;
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = (k == k_last) ? ST_FIX : ST_MUL;
      ST_FIX: begin
        if (is_div) begin
          state_next = (den == '0) ? ST_DONE : ST_DIV;
        end else if (func_r == FUNC_POW && exp_r != 4'd1) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (dstat.done && div_part) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (state == ST_FIX && is_div && den != '0) begin
        div_start <= 1'b1;
      end else if (state == ST_DIV && dstat.done && !div_part) begin
        div_start <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          func_r   <= func;
          exp_r    <= n_in;
          k        <= K_RE_RE;
          acc_re   <= '0;
          acc_im   <= '0;
          den      <= '0;
          sat_r    <= 1'b0;
          div0     <= 1'b0;
          div_part <= 1'b0;
          case (func)
            FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
              xr <= a_re;
              xi <= a_im;
              yr <= b_re;
              yi <= b_im;
            end
            FUNC_POW: begin
              xr <= WORD_BITS'(1) <<< FRAC_BITS;
              xi <= '0;
              yr <= a_re;
              yi <= a_im;
            end
            default: begin
              xr <= '0;
              xi <= '0;
              yr <= '0;
              yi <= '0;
            end
          endcase
        end
      end
      ST_ADD: begin
        xr    <= sre.val;
        xi    <= sim.val;
        sat_r <= sre.sat | sim.sat;
      end
      ST_ACC: begin
        case (k)
          K_RE_RE:  acc_re <= acc_re + pe;
          K_IM_IM:  acc_re <= is_div ? acc_re + pe : acc_re - pe;
          K_RE_IM:  acc_im <= is_div ? acc_im - pe : acc_im + pe;
          K_IM_RE:  acc_im <= acc_im + pe;
          K_DEN_RE: den    <= p[PROD_BITS-1:0];
          K_DEN_IM: den    <= den + p[PROD_BITS-1:0];
          default:  acc_re <= acc_re;
        endcase
        if (k != k_last) begin
          k <= k + 3'd1;
        end
      end
      ST_FIX: begin
        if (is_div) begin
          if (den == '0) begin
            xr   <= '0;
            xi   <= '0;
            div0 <= 1'b1;
          end
        end else begin
          xr     <= fre.val;
          xi     <= fim.val;
          sat_r  <= sat_r | fre.sat | fim.sat;
          exp_r  <= exp_r - 4'd1;
          k      <= K_RE_RE;
          acc_re <= '0;
          acc_im <= '0;
        end
      end
      ST_DIV: begin
        if (dstat.done) begin
          sat_r <= sat_r | qs.sat;
          if (div_part) begin
            xi <= qs.val;
          end else begin
            xr       <= qs.val;
            div_part <= 1'b1;
          end
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      res_re <= xr;
      res_im <= xi;
      status <= div0 ? STATUS_DIV0 : (sat_r ? STATUS_SAT : STATUS_OK);
    end
  end

endmodule
`default_nettype wire
